FILE: src/sip_pkg.sv
// Shared types, widths and status codes of the segment intersection block.
package sip_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int CW    = COORD_BITS;
    localparam int AW    = CW + 1;
    localparam int PW    = 2 * CW + 1;
    localparam int DPW   = 2 * AW;
    localparam int CCW   = 2 * CW + 2;
    localparam int DW    = 2 * CW + 3;
    localparam int MW    = CCW + AW;
    localparam int NW    = 3 * CW + 4;
    localparam int SW    = NW + FRAC_BITS;
    localparam int QB    = CW + FRAC_BITS + 1;
    localparam int QW    = QB + 1;
    localparam int OUT_W = 32;
    localparam int XW    = (QW > OUT_W) ? QW : OUT_W;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [1:0] ST_HIT = 2'd0;
    localparam logic [1:0] ST_PAR = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] by0;
        logic signed [CW-1:0] bx1;
        logic signed [CW-1:0] by1;
    } sip_coords_t;

    typedef struct packed {
        sip_coords_t          crd;
        logic signed [DW-1:0] det;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic                 par;
    } sip_item_t;

    typedef struct packed {
        logic signed [CW-1:0] xa_lo;
        logic signed [CW-1:0] xa_hi;
        logic signed [CW-1:0] ya_lo;
        logic signed [CW-1:0] ya_hi;
        logic signed [CW-1:0] xb_lo;
        logic signed [CW-1:0] xb_hi;
        logic signed [CW-1:0] yb_lo;
        logic signed [CW-1:0] yb_hi;
    } sip_bounds_t;

    typedef struct packed {
        sip_bounds_t   bnd;
        logic          par;
        logic          ovx;
        logic          ovy;
        logic          negx;
        logic          negy;
        logic [DW-1:0] dmag;
        logic [QB-1:0] nlx;
        logic [QB-1:0] nly;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
    } sip_bstage_t;

endpackage

FILE: src/sip_front.sv
// Front pipeline: line coefficients, determinant and Cramer numerators.
module sip_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sip_pkg::sip_coords_t         crd,
    output logic                         item_valid,
    input  logic                         item_ready,
    output sip_pkg::sip_item_t           item
);
    import sip_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    sip_coords_t           s1_crd_reg, s2_crd_reg, s3_crd_reg;
    logic signed [AW-1:0]  s1_a1_reg, s1_b1_reg, s1_a2_reg, s1_b2_reg;
    logic signed [AW-1:0]  s2_a1_reg, s2_b1_reg, s2_a2_reg, s2_b2_reg;
    logic signed [PW-1:0]  s1_pa1_reg, s1_pb1_reg, s1_pa2_reg, s1_pb2_reg;
    logic signed [DPW-1:0] s1_d1_reg, s1_d2_reg;
    logic signed [CCW-1:0] s2_c1_reg, s2_c2_reg;
    logic signed [DW-1:0]  s2_det_reg, s3_det_reg;
    logic signed [MW-1:0]  s3_m1_reg, s3_m2_reg, s3_m3_reg, s3_m4_reg;
    sip_item_t             item_reg;

    logic signed [AW-1:0]  a1_next, b1_next, a2_next, b2_next;
    sip_item_t             item_next;

    assign en         = !v4_reg || item_ready;
    assign in_ready   = en;
    assign item_valid = v4_reg;
    assign item       = item_reg;

    assign a1_next = AW'(crd.ay0) - AW'(crd.ay1);
    assign b1_next = AW'(crd.ax1) - AW'(crd.ax0);
    assign a2_next = AW'(crd.by0) - AW'(crd.by1);
    assign b2_next = AW'(crd.bx1) - AW'(crd.bx0);

    always_comb
    begin
        item_next.crd = s3_crd_reg;
        item_next.det = s3_det_reg;
        item_next.nx  = NW'(s3_m1_reg) - NW'(s3_m2_reg);
        item_next.ny  = NW'(s3_m3_reg) - NW'(s3_m4_reg);
        item_next.par = (s3_det_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_crd_reg <= crd;
            s1_a1_reg  <= a1_next;
            s1_b1_reg  <= b1_next;
            s1_a2_reg  <= a2_next;
            s1_b2_reg  <= b2_next;
            s1_pa1_reg <= a1_next * crd.ax0;
            s1_pb1_reg <= b1_next * crd.ay0;
            s1_pa2_reg <= a2_next * crd.bx0;
            s1_pb2_reg <= b2_next * crd.by0;
            s1_d1_reg  <= a1_next * b2_next;
            s1_d2_reg  <= a2_next * b1_next;

            s2_crd_reg <= s1_crd_reg;
            s2_a1_reg  <= s1_a1_reg;
            s2_b1_reg  <= s1_b1_reg;
            s2_a2_reg  <= s1_a2_reg;
            s2_b2_reg  <= s1_b2_reg;
            s2_c1_reg  <= CCW'(0) - CCW'(s1_pa1_reg) - CCW'(s1_pb1_reg);
            s2_c2_reg  <= CCW'(0) - CCW'(s1_pa2_reg) - CCW'(s1_pb2_reg);
            s2_det_reg <= DW'(s1_d1_reg) - DW'(s1_d2_reg);

            s3_crd_reg <= s2_crd_reg;
            s3_det_reg <= s2_det_reg;
            s3_m1_reg  <= s2_c2_reg * s2_b1_reg;
            s3_m2_reg  <= s2_c1_reg * s2_b2_reg;
            s3_m3_reg  <= s2_a2_reg * s2_c1_reg;
            s3_m4_reg  <= s2_a1_reg * s2_c2_reg;

            item_reg   <= item_next;
        end
    end

endmodule

FILE: src/sip_queue.sv
// Short queue between the front pipeline and the divider back end.
module sip_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  sip_pkg::sip_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output sip_pkg::sip_item_t rd_item
);
    import sip_pkg::*;

    sip_item_t        mem [0:QDEPTH-1];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: src/sip_back.sv
// Back end: pipelined restoring dividers, floor, range test and output register.
module sip_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  sip_pkg::sip_item_t             item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic signed [sip_pkg::OUT_W-1:0] cross_x,
    output logic signed [sip_pkg::OUT_W-1:0] cross_y
);
    import sip_pkg::*;

    function automatic sip_bstage_t div_next(input sip_bstage_t s);
        sip_bstage_t   r;
        logic [DW:0]   tx, ty;
        logic          gx, gy;
        r  = s;
        tx = {s.rx, s.nlx[QB-1]};
        ty = {s.ry, s.nly[QB-1]};
        gx = (tx >= {1'b0, s.dmag});
        gy = (ty >= {1'b0, s.dmag});
        r.rx  = gx ? DW'(tx - {1'b0, s.dmag}) : tx[DW-1:0];
        r.ry  = gy ? DW'(ty - {1'b0, s.dmag}) : ty[DW-1:0];
        r.nlx = {s.nlx[QB-2:0], 1'b0};
        r.nly = {s.nly[QB-2:0], 1'b0};
        r.qx  = {s.qx[QB-2:0], gx};
        r.qy  = {s.qy[QB-2:0], gy};
        return r;
    endfunction

    function automatic logic in_rng(input logic signed [QW-1:0] v,
                                    input logic signed [CW-1:0] lo,
                                    input logic signed [CW-1:0] hi);
        logic signed [QW-1:0] l, h;
        l = QW'(lo) <<< FRAC_BITS;
        h = QW'(hi) <<< FRAC_BITS;
        return (v >= l) && (v <= h);
    endfunction

    logic                 en;
    logic [QB:0]          v_reg;
    sip_bstage_t          st_reg [0:QB];
    sip_bstage_t          st0_next;
    logic                 out_valid_reg;
    logic [1:0]           status_reg, status_next;
    logic signed [OUT_W-1:0] cross_x_reg, cross_x_next, cross_y_reg, cross_y_next;

    logic signed [SW-1:0] sx, sy;
    logic [SW-1:0]        mx, my, dsh;
    logic                 sxn, syn, dneg;
    logic signed [QW-1:0] qex, qey, fx, fy;
    logic signed [XW-1:0] wx, wy;
    logic                 hit;

    assign en         = !out_valid_reg || out_ready;
    assign item_ready = en;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign cross_x    = cross_x_reg;
    assign cross_y    = cross_y_reg;

    always_comb
    begin
        sx   = SW'(item.nx) <<< FRAC_BITS;
        sy   = SW'(item.ny) <<< FRAC_BITS;
        sxn  = sx[SW-1];
        syn  = sy[SW-1];
        dneg = item.det[DW-1];
        mx   = sxn ? SW'(SW'(0) - sx) : SW'(sx);
        my   = syn ? SW'(SW'(0) - sy) : SW'(sy);
        st0_next.dmag = dneg ? DW'(DW'(0) - item.det) : DW'(item.det);
        dsh  = SW'(st0_next.dmag) << QB;
        st0_next.par  = item.par;
        st0_next.negx = sxn ^ dneg;
        st0_next.negy = syn ^ dneg;
        st0_next.ovx  = (mx >= dsh);
        st0_next.ovy  = (my >= dsh);
        st0_next.rx   = mx[SW-1:QB];
        st0_next.ry   = my[SW-1:QB];
        st0_next.nlx  = mx[QB-1:0];
        st0_next.nly  = my[QB-1:0];
        st0_next.qx   = '0;
        st0_next.qy   = '0;
        st0_next.bnd.xa_lo = (item.crd.ax0 < item.crd.ax1) ? item.crd.ax0 : item.crd.ax1;
        st0_next.bnd.xa_hi = (item.crd.ax0 < item.crd.ax1) ? item.crd.ax1 : item.crd.ax0;
        st0_next.bnd.ya_lo = (item.crd.ay0 < item.crd.ay1) ? item.crd.ay0 : item.crd.ay1;
        st0_next.bnd.ya_hi = (item.crd.ay0 < item.crd.ay1) ? item.crd.ay1 : item.crd.ay0;
        st0_next.bnd.xb_lo = (item.crd.bx0 < item.crd.bx1) ? item.crd.bx0 : item.crd.bx1;
        st0_next.bnd.xb_hi = (item.crd.bx0 < item.crd.bx1) ? item.crd.bx1 : item.crd.bx0;
        st0_next.bnd.yb_lo = (item.crd.by0 < item.crd.by1) ? item.crd.by0 : item.crd.by1;
        st0_next.bnd.yb_hi = (item.crd.by0 < item.crd.by1) ? item.crd.by1 : item.crd.by0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QB-1:0], item_valid};
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= div_next(st_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        qex = $signed({1'b0, st_reg[QB].qx});
        qey = $signed({1'b0, st_reg[QB].qy});
        fx  = st_reg[QB].negx ? (QW'(0) - qex - QW'(st_reg[QB].rx != '0)) : qex;
        fy  = st_reg[QB].negy ? (QW'(0) - qey - QW'(st_reg[QB].ry != '0)) : qey;
        wx  = XW'(fx);
        wy  = XW'(fy);
        hit = !st_reg[QB].ovx && !st_reg[QB].ovy &&
              in_rng(fx, st_reg[QB].bnd.xa_lo, st_reg[QB].bnd.xa_hi) &&
              in_rng(fx, st_reg[QB].bnd.xb_lo, st_reg[QB].bnd.xb_hi) &&
              in_rng(fy, st_reg[QB].bnd.ya_lo, st_reg[QB].bnd.ya_hi) &&
              in_rng(fy, st_reg[QB].bnd.yb_lo, st_reg[QB].bnd.yb_hi);
        priority if (st_reg[QB].par)
        begin
            status_next  = ST_PAR;
            cross_x_next = '0;
            cross_y_next = '0;
        end
        else if (hit)
        begin
            status_next  = ST_HIT;
            cross_x_next = wx[OUT_W-1:0];
            cross_y_next = wy[OUT_W-1:0];
        end
        else
        begin
            status_next  = ST_OUT;
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg  <= status_next;
            cross_x_reg <= cross_x_next;
            cross_y_reg <= cross_y_next;
        end
    end

endmodule

FILE: src/segment_intersection_point.sv
// Top level of the segment intersection block.
// Takes one pair of segments per clock while in_ready is high and returns one transaction
// per pair, in order, carrying status (hit, parallel or outside) and the floored crossing
// point. The accept edge loads the first of four coefficient stages. Items then pass
// through the four-entry queue, one divider input stage, one restoring-divider stage per
// quotient bit (COORD_BITS + FRAC_BITS + 1) and the output register. Each side stalls on
// its own through the queue.
module segment_intersection_point (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [sip_pkg::OUT_W-1:0]   cross_x,
    output logic signed [sip_pkg::OUT_W-1:0]   cross_y
);
    import sip_pkg::*;

    sip_coords_t crd;
    sip_item_t   f_item, q_item;
    logic        f_valid, f_ready, q_valid, q_ready;

    assign crd.ax0 = a_start_x;
    assign crd.ay0 = a_start_y;
    assign crd.ax1 = a_end_x;
    assign crd.ay1 = a_end_y;
    assign crd.bx0 = b_start_x;
    assign crd.by0 = b_start_y;
    assign crd.bx1 = b_end_x;
    assign crd.by1 = b_end_y;

    sip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .crd        (crd),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    sip_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    sip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cross_x    (cross_x),
        .cross_y    (cross_y)
    );

endmodule

FILE: src/sip_checker.sv
// Port-level checker for the segment intersection block, bound to the top level.
module sip_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_y,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [1:0]                         status,
    input  logic signed [sip_pkg::OUT_W-1:0]   cross_x,
    input  logic signed [sip_pkg::OUT_W-1:0]   cross_y
);
    import sip_pkg::*;

    logic [7:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_HIT |-> cross_x == '0 && cross_y == '0)
        else $error("Non-hit transaction carries a nonzero point.");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("Output transaction without a pending input transaction.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(cross_x) && $stable(cross_y))
        else $error("Stalled output transaction changed.");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);
